// ===== sv/bsbe_pkg.sv =====
// ----------------------------------------------------------------------------
// bsbe_pkg: shared types and constants for the bit-stuffing byte encoder
// Request and result payloads, the front-to-back command and the queue status.
// ----------------------------------------------------------------------------
package bsbe_pkg;

  localparam int unsigned ByteBits     = 8;
  localparam int unsigned RunLimit     = 3;
  // 8 data bits plus at most 3 stuffed zeros
  localparam int unsigned StuffBits    = 11;
  localparam int unsigned StuffLenBits = 4;
  localparam int unsigned CountBits    = 3;
  localparam int unsigned RunBits      = 2;
  localparam int unsigned QueueDepth   = 2;

  // request kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ByteBits-1:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last;
  } out_t;

  // stuffed bits, left-aligned, with their count
  typedef struct packed {
    logic                    kind;
    logic [StuffBits-1:0]    bits;
    logic [StuffLenBits-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/bsbe_front.sv =====
// ----------------------------------------------------------------------------
// bsbe_front: request intake and bit stuffing
// Tracks the ones run and turns each data byte into a stuffed bit group.
// ----------------------------------------------------------------------------
module bsbe_front
  import bsbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_t       item,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      cmd
);

  logic [RunBits-1:0]      ones_run;
  logic [RunBits-1:0]      ones_run_next;
  logic [RunBits-1:0]      run_scan;
  logic [StuffBits-1:0]    acc;
  logic [StuffLenBits-1:0] len;

  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full;

  // Stuff one byte MSB first: a zero after every third one in a row
  always_comb begin
    run_scan = ones_run;
    acc      = '0;
    len      = '0;
    for (int i = ByteBits - 1; i >= 0; i--) begin
      acc = {acc[StuffBits-2:0], item.in_byte[i]};
      len = len + 1'b1;
      if (item.in_byte[i]) begin
        run_scan = run_scan + 1'b1;
      end else begin
        run_scan = '0;
      end
      if (run_scan == RunBits'(RunLimit)) begin
        acc      = {acc[StuffBits-2:0], 1'b0};
        len      = len + 1'b1;
        run_scan = '0;
      end
    end
  end

  // Command to the back end, bits left-aligned
  always_comb begin
    cmd.kind = item.kind;
    cmd.bits = acc << (StuffLenBits'(StuffBits) - len);
    cmd.len  = len;
  end

  // Flush clears the run
  always_comb begin
    if (item.kind == KIND_FLUSH) begin
      ones_run_next = '0;
    end else begin
      ones_run_next = run_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_run <= '0;
    end else if (push) begin
      ones_run <= ones_run_next;
    end
  end

endmodule

// ===== sv/bsbe_queue.sv =====
// ----------------------------------------------------------------------------
// bsbe_queue: short command queue between front and back
// Register-based circular buffer, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module bsbe_queue
  import bsbe_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  cmd_t               entries [DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == CntBits'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bsbe_back.sv =====
// ----------------------------------------------------------------------------
// bsbe_back: bit packing and result output
// Merges pending bits with data groups into one or two bytes; flush drains.
// ----------------------------------------------------------------------------
module bsbe_back
  import bsbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_t      result
);

  localparam int unsigned WordBits = ByteBits + StuffBits;
  localparam int unsigned TotBits  = 5;

  logic [ByteBits-1:0]  pend_bits;
  logic [CountBits-1:0] pend_cnt;
  logic                 hold_valid;
  logic [ByteBits-1:0]  hold_byte;
  logic                 can_load;
  logic [WordBits-1:0]  word;
  logic [TotBits-1:0]   total;
  logic                 two;

  assign can_load = !result_valid || !result_stall;
  assign pop      = can_load && !hold_valid && !q_status.empty;

  // Pending bits on top, new group right behind them
  always_comb begin
    word  = {pend_bits, {StuffBits{1'b0}}}
          | ({head.bits, {ByteBits{1'b0}}} >> pend_cnt);
    total = TotBits'(pend_cnt) + TotBits'(head.len);
    two   = (total >= TotBits'(2 * ByteBits));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits    <= '0;
      pend_cnt     <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else if (can_load) begin
      if (hold_valid) begin
        // second byte of a data request
        result.out_byte <= hold_byte;
        result.last     <= 1'b1;
        result_valid    <= 1'b1;
        hold_valid      <= 1'b0;
      end else if (pop) begin
        if (head.kind == KIND_FLUSH) begin
          result.out_byte <= pend_bits;
          result.last     <= 1'b1;
          result_valid    <= (pend_cnt != '0);
          pend_bits       <= '0;
          pend_cnt        <= '0;
        end else begin
          result.out_byte <= word[WordBits-1 -: ByteBits];
          result.last     <= !two;
          result_valid    <= 1'b1;
          hold_valid      <= two;
          hold_byte       <= word[WordBits-ByteBits-1 -: ByteBits];
          if (two) begin
            pend_bits <= {word[WordBits-2*ByteBits-1:0],
                          {(3*ByteBits-WordBits){1'b0}}};
            pend_cnt  <= CountBits'(total - TotBits'(2 * ByteBits));
          end else begin
            pend_bits <= word[WordBits-ByteBits-1 -: ByteBits];
            pend_cnt  <= CountBits'(total - TotBits'(ByteBits));
          end
        end
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/bit_stuffing_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// bit_stuffing_byte_encoder: bit-stuffing encoder, byte in, bytes out
// Inserts a zero after three ones in a row and repacks the stream into bytes.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item      item_valid/item_stall  in_t   {kind, in_byte}
//  result    result_valid/stall     out_t  {out_byte, last}
//
//  A request is taken every cycle while the command queue has room.
//  A data request gives one or two result bytes, one per cycle from the
//  output register unless stalled; the second byte blocks new pops.
//  A result is registered in the queue, then in the output register.
//  Synchronous reset clears the run count, pending bits and queue.
//  Result stall backs up the queue, then raises item_stall.
// ----------------------------------------------------------------------------
module bit_stuffing_byte_encoder
  import bsbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  in_t  item,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;

  bsbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .cmd        (push_cmd)
  );

  bsbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  bsbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== sv/bsbe_checker.sv =====
// ----------------------------------------------------------------------------
// bsbe_checker: port-level checks for the bit-stuffing byte encoder
// Result ordering and reset behavior as seen on the top-level ports.
// ----------------------------------------------------------------------------
module bsbe_checker
  import bsbe_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic item_stall,
  input logic result_valid,
  input logic result_stall,
  input out_t result
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a non-final byte is followed at once by the final one
  a_second_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.last |=> result_valid && result.last)
    else $error("second result byte missing");

  // nothing pending out of reset
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // queue empty out of reset
  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> !item_stall)
    else $error("item stalled right after reset");

endmodule

bind bit_stuffing_byte_encoder bsbe_checker u_bsbe_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
